>>> sv/eol_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and character constants for the expression operator lexer.
// No dependencies; every other file refers to this package by scoped names.
package eol_pkg;

  localparam int NumCodes = 6;
  localparam int CfgIdxW  = 3;

  typedef enum logic [2:0] {
    REG_AND           = 3'd0,
    REG_OR            = 3'd1,
    REG_EQUAL         = 3'd2,
    REG_GREATER_EQUAL = 3'd3,
    REG_LESS_EQUAL    = 3'd4,
    REG_NOT_EQUAL     = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_QUOTE   = 2'd1,
    STAT_INVALID = 2'd2
  } status_t;

  typedef enum logic [7:0] {
    ST_NORM  = 8'b0000_0001,
    ST_QUOTE = 8'b0000_0010,
    ST_AND   = 8'b0000_0100,
    ST_OR    = 8'b0000_1000,
    ST_EQ    = 8'b0001_0000,
    ST_GE    = 8'b0010_0000,
    ST_LE    = 8'b0100_0000,
    ST_NOT   = 8'b1000_0000
  } lex_state_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_BANG  = 8'h21;

  typedef logic [NumCodes-1:0][7:0] codes_t;

  localparam codes_t CODES_RESET = {8'd64, 8'd37, 8'd96, 8'd92, 8'd63, 8'd126};

  typedef struct packed {
    logic [7:0] ch;
    logic       is_status;
    logic [1:0] status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } pair_t;

  function automatic res_t char_res(input logic [7:0] ch, input logic last);
    res_t r;
    r.ch        = ch;
    r.is_status = 1'b0;
    r.status    = STAT_OK;
    r.last      = last;
    return r;
  endfunction

endpackage

>>> sv/expression_operator_lexer.sv
`timescale 1ns / 1ps
// Expression operator lexer: rewrites a character stream and folds two-character operators.
// Top level; instantiates eol_cfg_regs, eol_lex and eol_obuf, all built on eol_pkg.
//
// The input channel carries one item per transfer: a character or an end marker.
// Each item yields zero, one or two results on the output channel; the final result
// of an item has out_last set, and an end marker yields one status result.
// An item passes through an input register, the lexer decode and a result register.
// The first result of an item is presented from the result register once the item has
// passed the input register and the lexer decode.
// Items that yield one result or none are taken at one per cycle while the receiver
// does not stall. An item that yields two results holds the result register for two
// transfers, so a broken operator holds back the items behind it until both are taken.
// When the receiver stalls, the result register holds, then the input register
// fills, and in_stall rises; no item or result is lost.
// A synchronous reset with rst_n low empties both registers, returns the lexer to
// its normal state and loads the default operator codes.
// The operator codes are written on cfg_we with cfg_index 0 to 5, other indexes being
// ignored; the user must write them only while idle, the block does not enforce this.
module expression_operator_lexer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_command,
  input  logic [7:0]                in_char_code,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_char,
  output logic                      out_is_status,
  output logic [1:0]                out_status,
  output logic                      out_last,
  input  logic                      cfg_we,
  input  logic [eol_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [7:0]                cfg_data
);

  eol_pkg::codes_t codes;
  eol_pkg::pair_t  pair;
  logic            adv;

  eol_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .codes     (codes)
  );

  eol_lex u_lex (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_char_code (in_char_code),
    .codes        (codes),
    .adv          (adv),
    .pair         (pair)
  );

  eol_obuf u_obuf (
    .clk           (clk),
    .rst_n         (rst_n),
    .pair          (pair),
    .adv           (adv),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_is_status (out_is_status),
    .out_status    (out_status),
    .out_last      (out_last)
  );

endmodule

>>> sv/eol_cfg_regs.sv
`timescale 1ns / 1ps
// Operator code registers written through the plain configuration port.
// Depends on eol_pkg for the register indexes and reset values.
module eol_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [eol_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [7:0]                cfg_data,
  output eol_pkg::codes_t           codes
);

  eol_pkg::codes_t codes_r;
  eol_pkg::codes_t codes_nxt;

  always_comb begin
    codes_nxt = codes_r;
    if (cfg_we) begin
      case (cfg_index)
        eol_pkg::REG_AND:           codes_nxt[0] = cfg_data;
        eol_pkg::REG_OR:            codes_nxt[1] = cfg_data;
        eol_pkg::REG_EQUAL:         codes_nxt[2] = cfg_data;
        eol_pkg::REG_GREATER_EQUAL: codes_nxt[3] = cfg_data;
        eol_pkg::REG_LESS_EQUAL:    codes_nxt[4] = cfg_data;
        eol_pkg::REG_NOT_EQUAL:     codes_nxt[5] = cfg_data;
        default:                    codes_nxt = codes_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r <= eol_pkg::CODES_RESET;
    end else begin
      codes_r <= codes_nxt;
    end
  end

  assign codes = codes_r;

endmodule

>>> sv/eol_lex.sv
`timescale 1ns / 1ps
// Input register, lexer state and the decode that turns one item into up to two results.
// Depends on eol_pkg; hands a result pair to eol_obuf when that buffer can take it.
module eol_lex (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_command,
  input  logic [7:0]      in_char_code,
  input  eol_pkg::codes_t codes,
  input  logic            adv,
  output eol_pkg::pair_t  pair
);

  logic                vld_r;
  logic                vld_nxt;
  logic                cmd_r;
  logic [7:0]          ch_r;
  eol_pkg::lex_state_t state_r;
  eol_pkg::lex_state_t state_nxt;
  eol_pkg::pair_t      pair_c;
  logic [7:0]          pend_ch;
  logic [7:0]          partner;
  logic [7:0]          op_code;
  logic                accept;

  assign in_stall = vld_r && !adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    pend_ch = eol_pkg::CH_BANG;
    partner = eol_pkg::CH_EQ;
    op_code = codes[5];
    case (state_r)
      eol_pkg::ST_AND: begin
        pend_ch = eol_pkg::CH_AMP;
        partner = eol_pkg::CH_AMP;
        op_code = codes[0];
      end
      eol_pkg::ST_OR: begin
        pend_ch = eol_pkg::CH_BAR;
        partner = eol_pkg::CH_BAR;
        op_code = codes[1];
      end
      eol_pkg::ST_EQ: begin
        pend_ch = eol_pkg::CH_EQ;
        op_code = codes[2];
      end
      eol_pkg::ST_GE: begin
        pend_ch = eol_pkg::CH_GT;
        op_code = codes[3];
      end
      eol_pkg::ST_LE: begin
        pend_ch = eol_pkg::CH_LT;
        op_code = codes[4];
      end
      default: begin
        pend_ch = eol_pkg::CH_BANG;
        partner = eol_pkg::CH_EQ;
        op_code = codes[5];
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    pair_c.vld = vld_r;
    pair_c.cnt = 2'd0;
    pair_c.r0  = eol_pkg::char_res(ch_r, 1'b1);
    pair_c.r1  = eol_pkg::char_res(ch_r, 1'b1);
    if (cmd_r) begin
      state_nxt           = eol_pkg::ST_NORM;
      pair_c.cnt          = 2'd1;
      pair_c.r0.ch        = 8'd0;
      pair_c.r0.is_status = 1'b1;
      case (state_r)
        eol_pkg::ST_NORM:  pair_c.r0.status = eol_pkg::STAT_OK;
        eol_pkg::ST_QUOTE: pair_c.r0.status = eol_pkg::STAT_QUOTE;
        default:           pair_c.r0.status = eol_pkg::STAT_INVALID;
      endcase
    end else begin
      case (state_r)
        eol_pkg::ST_NORM: begin
          pair_c.cnt = 2'd0;
          case (ch_r)
            eol_pkg::CH_SPACE: state_nxt = eol_pkg::ST_NORM;
            eol_pkg::CH_AMP:   state_nxt = eol_pkg::ST_AND;
            eol_pkg::CH_BAR:   state_nxt = eol_pkg::ST_OR;
            eol_pkg::CH_EQ:    state_nxt = eol_pkg::ST_EQ;
            eol_pkg::CH_GT:    state_nxt = eol_pkg::ST_GE;
            eol_pkg::CH_LT:    state_nxt = eol_pkg::ST_LE;
            eol_pkg::CH_BANG:  state_nxt = eol_pkg::ST_NOT;
            eol_pkg::CH_QUOTE: begin
              state_nxt  = eol_pkg::ST_QUOTE;
              pair_c.cnt = 2'd1;
            end
            default:           pair_c.cnt = 2'd1;
          endcase
        end
        eol_pkg::ST_QUOTE: begin
          pair_c.cnt = 2'd1;
          if (ch_r == eol_pkg::CH_QUOTE) begin
            state_nxt = eol_pkg::ST_NORM;
          end
        end
        eol_pkg::ST_AND, eol_pkg::ST_OR, eol_pkg::ST_EQ,
        eol_pkg::ST_GE, eol_pkg::ST_LE, eol_pkg::ST_NOT: begin
          state_nxt = eol_pkg::ST_NORM;
          if (ch_r == partner) begin
            pair_c.cnt = 2'd1;
            pair_c.r0  = eol_pkg::char_res(op_code, 1'b1);
          end else if (ch_r == eol_pkg::CH_SPACE) begin
            pair_c.cnt = 2'd1;
            pair_c.r0  = eol_pkg::char_res(pend_ch, 1'b1);
          end else begin
            pair_c.cnt = 2'd2;
            pair_c.r0  = eol_pkg::char_res(pend_ch, 1'b0);
          end
        end
        default: begin
          state_nxt  = eol_pkg::ST_NORM;
          pair_c.cnt = 2'd0;
        end
      endcase
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      state_r <= eol_pkg::ST_NORM;
    end else begin
      vld_r <= vld_nxt;
      if (vld_r && adv) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      ch_r  <= in_char_code;
    end
  end

  assign pair = pair_c;

endmodule

>>> sv/eol_obuf.sv
`timescale 1ns / 1ps
// Result register that holds one result pair and presents it one result per transfer.
// Depends on eol_pkg; signals eol_lex when the next pair may be loaded.
module eol_obuf (
  input  logic           clk,
  input  logic           rst_n,
  input  eol_pkg::pair_t pair,
  output logic           adv,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_char,
  output logic           out_is_status,
  output logic [1:0]     out_status,
  output logic           out_last
);

  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;
  logic          idx_r;
  logic          idx_nxt;
  eol_pkg::res_t r0_r;
  eol_pkg::res_t r1_r;
  eol_pkg::res_t cur;
  logic          take;
  logic          finish;

  assign out_valid = (cnt_r != 2'd0);
  assign take      = out_valid && !out_stall;
  assign finish    = take && ((cnt_r == 2'd1) || idx_r);
  assign adv       = !out_valid || finish;

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (adv) begin
      cnt_nxt = pair.vld ? pair.cnt : 2'd0;
      idx_nxt = 1'b0;
    end else if (take) begin
      idx_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && pair.vld) begin
      r0_r <= pair.r0;
      r1_r <= pair.r1;
    end
  end

  assign cur           = idx_r ? r1_r : r0_r;
  assign out_char      = cur.ch;
  assign out_is_status = cur.is_status;
  assign out_status    = cur.status;
  assign out_last      = cur.last;

endmodule

>>> sv/eol_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the expression operator lexer, bound to the top level.
// Depends on eol_pkg for the status codes.
module eol_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic       out_is_status,
  input logic [1:0] out_status,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_last)
      && $stable(out_is_status) && $stable(out_status))
    else $error("stalled result changed");

  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_status |-> out_last && (out_char == 8'd0)
      && (out_status != 2'd3))
    else $error("malformed status result");

  a_char_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_status |-> out_status == eol_pkg::STAT_OK)
    else $error("character result carries a status");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind expression_operator_lexer eol_checker u_eol_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_char      (out_char),
  .out_is_status (out_is_status),
  .out_status    (out_status),
  .out_last      (out_last)
);

>>> tb/sv/expression_operator_lexer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for expression_operator_lexer: directed and random character streams.
// Depends on eol_pkg and the expression_operator_lexer RTL; needs no other files.
module expression_operator_lexer_tb;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 6;

  localparam logic [eol_pkg::NumCodes-1:0][7:0] OpLead =
    {eol_pkg::CH_BANG, eol_pkg::CH_LT, eol_pkg::CH_GT, eol_pkg::CH_EQ, eol_pkg::CH_BAR,
     eol_pkg::CH_AMP};
  localparam logic [eol_pkg::NumCodes-1:0][7:0] OpTail =
    {eol_pkg::CH_EQ, eol_pkg::CH_EQ, eol_pkg::CH_EQ, eol_pkg::CH_EQ, eol_pkg::CH_BAR,
     eol_pkg::CH_AMP};

  typedef struct packed {
    logic [7:0]       ch;
    logic             is_status;
    eol_pkg::status_t status;
    logic             last;
  } lexeme_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        in_command = 1'b0;
  logic [7:0]                  in_char_code = 8'h00;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [7:0]                  out_char;
  logic                        out_is_status;
  logic [1:0]                  out_status;
  logic                        out_last;
  logic                        cfg_we = 1'b0;
  logic [eol_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [7:0]                  cfg_data = 8'h00;

  lexeme_t             expected_lexemes[$];
  lexeme_t             head_lexeme;
  eol_pkg::lex_state_t pred_state = eol_pkg::ST_NORM;
  logic [7:0]          code_byte [eol_pkg::NumCodes] =
    '{8'd126, 8'd63, 8'd92, 8'd96, 8'd37, 8'd64};

  int  errors = 0;
  int  cycles = 0;
  int  items_sent = 0;
  bit  gap_on = 1'b1;
  bit  stall_on = 1'b1;
  int  hold_req = 0;
  int  hold_cnt = 0;
  int  seg_left = 0;
  bit  seg_busy = 1'b0;

  expression_operator_lexer i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_is_status(out_is_status),
    .out_status   (out_status),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function void push_char(input logic [7:0] ch, input logic last);
    lexeme_t r;
    r.ch        = ch;
    r.is_status = 1'b0;
    r.status    = eol_pkg::STAT_OK;
    r.last      = last;
    expected_lexemes = {expected_lexemes, r};
  endfunction

  function void push_status(input eol_pkg::status_t st);
    lexeme_t r;
    r.ch        = 8'h00;
    r.is_status = 1'b1;
    r.status    = st;
    r.last      = 1'b1;
    expected_lexemes = {expected_lexemes, r};
  endfunction

  function void predict_lexemes(input logic cmd, input logic [7:0] ch);
    eol_pkg::reg_idx_t sel;
    sel = eol_pkg::REG_NOT_EQUAL;
    if (cmd) begin
      case (pred_state)
        eol_pkg::ST_NORM:  push_status(eol_pkg::STAT_OK);
        eol_pkg::ST_QUOTE: push_status(eol_pkg::STAT_QUOTE);
        default:           push_status(eol_pkg::STAT_INVALID);
      endcase
      pred_state = eol_pkg::ST_NORM;
    end else if (pred_state == eol_pkg::ST_NORM) begin
      case (ch)
        eol_pkg::CH_SPACE: ;
        eol_pkg::CH_AMP:   pred_state = eol_pkg::ST_AND;
        eol_pkg::CH_BAR:   pred_state = eol_pkg::ST_OR;
        eol_pkg::CH_EQ:    pred_state = eol_pkg::ST_EQ;
        eol_pkg::CH_GT:    pred_state = eol_pkg::ST_GE;
        eol_pkg::CH_LT:    pred_state = eol_pkg::ST_LE;
        eol_pkg::CH_BANG:  pred_state = eol_pkg::ST_NOT;
        default: begin
          if (ch == eol_pkg::CH_QUOTE) pred_state = eol_pkg::ST_QUOTE;
          push_char(ch, 1'b1);
        end
      endcase
    end else if (pred_state == eol_pkg::ST_QUOTE) begin
      if (ch == eol_pkg::CH_QUOTE) pred_state = eol_pkg::ST_NORM;
      push_char(ch, 1'b1);
    end else begin
      case (pred_state)
        eol_pkg::ST_AND: sel = eol_pkg::REG_AND;
        eol_pkg::ST_OR:  sel = eol_pkg::REG_OR;
        eol_pkg::ST_EQ:  sel = eol_pkg::REG_EQUAL;
        eol_pkg::ST_GE:  sel = eol_pkg::REG_GREATER_EQUAL;
        eol_pkg::ST_LE:  sel = eol_pkg::REG_LESS_EQUAL;
        default:         sel = eol_pkg::REG_NOT_EQUAL;
      endcase
      pred_state = eol_pkg::ST_NORM;
      if (ch == OpTail[sel]) begin
        push_char(code_byte[sel], 1'b1);
      end else if (ch == eol_pkg::CH_SPACE) begin
        push_char(OpLead[sel], 1'b1);
      end else begin
        push_char(OpLead[sel], 1'b0);
        push_char(ch, 1'b1);
      end
    end
  endfunction

  task automatic send_item(input logic cmd, input logic [7:0] ch);
    int gap;
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_char_code <= ch;
    do @(posedge clk); while (in_stall);
    predict_lexemes(cmd, ch);
    items_sent++;
    gap = (gap_on && $urandom_range(0, 1)) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_lexemes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Writes every index, the unused ones included, which the block must ignore.
  task automatic load_codes(input eol_pkg::codes_t codes);
    logic [7:0] junk;
    for (int i = 0; i < (1 << eol_pkg::CfgIdxW); i++) begin
      junk = 8'($urandom_range(0, 255));
      cfg_we    <= 1'b1;
      cfg_index <= i[eol_pkg::CfgIdxW-1:0];
      if (i < eol_pkg::NumCodes) begin
        cfg_data <= codes[i];
        code_byte[i] = codes[i];
      end else begin
        cfg_data <= junk;
      end
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_token();
    int         kind;
    int         idx;
    int         len;
    logic [7:0] rnd;
    kind = $urandom_range(0, 19);
    idx  = $urandom_range(0, eol_pkg::NumCodes - 1);
    rnd  = 8'($urandom_range(0, 255));
    if (kind < 6) begin
      rnd = 8'($urandom_range(33, 126));
      send_item(1'b0, rnd);
    end else if (kind < 11) begin
      send_item(1'b0, OpLead[idx]);
      if ($urandom_range(0, 7) == 0) send_item(1'b0, eol_pkg::CH_SPACE);
      send_item(1'b0, OpTail[idx]);
    end else if (kind < 13) begin
      send_item(1'b0, OpLead[idx]);
      send_item(1'b0, rnd);
    end else if (kind < 15) begin
      repeat ($urandom_range(1, 3)) send_item(1'b0, eol_pkg::CH_SPACE);
    end else if (kind < 17) begin
      send_item(1'b0, eol_pkg::CH_QUOTE);
      len = $urandom_range(0, 5);
      repeat (len) begin
        rnd = 8'($urandom_range(0, 255));
        if (rnd == eol_pkg::CH_QUOTE) rnd = eol_pkg::CH_SPACE;
        send_item(1'b0, rnd);
      end
      if ($urandom_range(0, 4) != 0) send_item(1'b0, eol_pkg::CH_QUOTE);
    end else if (kind < 19) begin
      send_item(1'b1, rnd);
    end else begin
      send_item(1'b0, rnd);
    end
  endtask

  task automatic test_directed_operators();
    send_text("&&||==>=<=!=");
    send_text("&=! ");
    send_text(" ");
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b1, 8'hFF);
    send_text("\" &\"");
    send_text("\"");
    send_item(1'b1, 8'h00);
    send_text(">");
    send_item(1'b1, 8'h5A);
    wait_idle();
  endtask

  task automatic test_random_expressions(input eol_pkg::codes_t codes, input int n_items);
    int stop_at;
    wait_idle();
    load_codes(codes);
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_random_token();
    wait_idle();
  endtask

  task automatic test_noise(input int n_items);
    logic       cmd;
    logic [7:0] rnd;
    repeat (n_items) begin
      cmd = ($urandom_range(0, 9) == 0);
      rnd = 8'($urandom_range(0, 255));
      send_item(cmd, rnd);
    end
    wait_idle();
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure(input int n_items);
    int stop_at;
    gap_on   = 1'b0;
    hold_req = 300;
    stop_at  = items_sent + n_items;
    while (items_sent < stop_at) send_random_token();
    gap_on = 1'b1;
    wait_idle();
  endtask

  task automatic test_full_rate(input int n_items);
    int stop_at;
    gap_on   = 1'b0;
    stall_on = 1'b0;
    stop_at  = items_sent + n_items;
    while (items_sent < stop_at) send_random_token();
    wait_idle();
    gap_on   = 1'b1;
    stall_on = 1'b1;
  endtask

  function automatic eol_pkg::codes_t random_codes();
    eol_pkg::codes_t c;
    for (int i = 0; i < eol_pkg::NumCodes; i++) c[i] = 8'($urandom_range(0, 255));
    return c;
  endfunction

  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (!stall_on) begin
      out_stall <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_busy = ($urandom_range(0, 2) == 0);
        seg_left = seg_busy ? pick_gap() : $urandom_range(1, 12);
      end
      seg_left--;
      out_stall <= seg_busy;
    end
  end

  function void check_field(input string name, input int unsigned want, input int unsigned got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_lexemes.size() == 0) begin
        $display("%0t: unexpected transfer, expected none actual char %0h status %0h",
                 $time, out_char, out_status);
        errors++;
      end else begin
        head_lexeme = expected_lexemes.pop_front();
        check_field("out_char", head_lexeme.ch, out_char);
        check_field("out_is_status", head_lexeme.is_status, out_is_status);
        check_field("out_status", head_lexeme.status, out_status);
        check_field("out_last", head_lexeme.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_operators();
    test_random_expressions('0, 180);
    test_random_expressions({eol_pkg::NumCodes{8'hFF}}, 180);
    test_random_expressions(random_codes(), 180);
    test_random_expressions({eol_pkg::CH_SPACE, eol_pkg::CH_QUOTE, eol_pkg::CH_BANG,
                             eol_pkg::CH_LT, eol_pkg::CH_EQ, eol_pkg::CH_AMP}, 180);
    test_noise(150);
    test_backpressure(60);
    test_full_rate(100);
    wait_idle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
